/* sv/pip_pkg.sv */
// Shared constants, operation codes and types for the point-in-polygon crossing-number block.
// Used by pip_edge_eval, point_in_polygon_test and the testbench; depends on nothing.
package pip_pkg;

	localparam int MAX_VERTICES = 128;
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int LEFT_W = $clog2(MAX_VERTICES + 2);
	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int NUM_W = PROD_W + 1;

	// Operation codes carried by the operation field; code 3 does nothing
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEST   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	// Status of the edge evaluator toward the sequencer
	typedef struct packed {
		logic busy;
		logic vld;
		logic r_hit;
		logic l_hit;
	} edge_res_t;

endpackage

/* sv/pip_edge_eval.sv */
// Two-stage edge evaluator: decides right and left crossings of one edge.
// Depends on pip_pkg for widths and the edge_res_t status struct.
module pip_edge_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               edge_vld,
	input  pip_pkg::diff_t     xi,
	input  pip_pkg::diff_t     yi,
	input  pip_pkg::diff_t     xj,
	input  pip_pkg::diff_t     yj,
	output pip_pkg::edge_res_t res
);

	logic                              vld_s1;
	logic signed [pip_pkg::PROD_W-1:0] prod_p_s1;
	logic signed [pip_pkg::PROD_W-1:0] prod_q_s1;
	logic                              rs_s1;
	logic                              ls_s1;
	logic                              sd_pos_s1;
	logic                              vld_s2;
	logic                              r_hit_s2;
	logic                              l_hit_s2;
	logic signed [pip_pkg::NUM_W-1:0]  num;
	logic                              num_zero;
	logic                              num_neg;
	logic                              sn_eq_sd;
	logic                              yi_pos;
	logic                              yj_pos;

	assign yi_pos = !yi[pip_pkg::DIFF_W-1] && (|yi);
	assign yj_pos = !yj[pip_pkg::DIFF_W-1] && (|yj);

	// Stage 1: products and straddle flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= edge_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_vld) begin
			prod_p_s1 <= xi * yj;
			prod_q_s1 <= xj * yi;
			rs_s1     <= yi_pos != yj_pos;
			ls_s1     <= yi[pip_pkg::DIFF_W-1] != yj[pip_pkg::DIFF_W-1];
			sd_pos_s1 <= yj > yi;
		end
	end

	// Stage 2: sign of the numerator against the sign of the denominator
	assign num = pip_pkg::NUM_W'(prod_p_s1) - pip_pkg::NUM_W'(prod_q_s1);
	assign num_zero = (num == '0);
	assign num_neg = num[pip_pkg::NUM_W-1];
	assign sn_eq_sd = num_neg ? !sd_pos_s1 : sd_pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			r_hit_s2 <= 1'b0;
			l_hit_s2 <= 1'b0;
		end else begin
			vld_s2   <= vld_s1;
			r_hit_s2 <= vld_s1 && rs_s1 && (num_zero || sn_eq_sd);
			l_hit_s2 <= vld_s1 && ls_s1 && (num_zero || !sn_eq_sd);
		end
	end

	assign res.busy  = vld_s1;
	assign res.vld   = vld_s2;
	assign res.r_hit = r_hit_s2;
	assign res.l_hit = l_hit_s2;

endmodule

/* sv/point_in_polygon_test.sv */
// Top level of the point-in-polygon block: vertex memory, walk sequencer, output register.
// Depends on pip_pkg and instantiates pip_edge_eval.
//
// Each item is one operation: clear the polygon, append a vertex, or test a query
// point (Q15.16 coordinates). Every item yields exactly one result item. A test
// reads the vertex memory once per cycle, starting with the last vertex so that
// the closing edge comes first, so it reads count+1 entries; each entry then
// passes the read register, the translate stage and the two evaluator stages, and
// the result is loaded once the pipeline is empty. The vertex memory's single
// read port paces the walk; a stalled output register holds the result back.
// Appends beyond capacity are refused and flagged with dropped; the count holds.
// A test on an empty polygon reports outside. The block takes one item at a time
// (in_stall is high while it works), but it accepts the next item while the last
// result still waits in the output register.
module point_in_polygon_test (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           operation,
	input  logic signed [31:0]   coord_x,
	input  logic signed [31:0]   coord_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 inside_res,
	output logic                 on_boundary,
	output logic [7:0]           vertex_total,
	output logic                 dropped
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [pip_pkg::CNT_W-1:0]    count_q;
	logic [pip_pkg::ADDR_W-1:0]   rd_idx_q;
	logic [pip_pkg::LEFT_W-1:0]   left_q;
	logic                         first_q;
	pip_pkg::coord_t              qx_q;
	pip_pkg::coord_t              qy_q;
	logic                         res_inside_q;
	logic                         res_edge_q;
	logic                         res_drop_q;
	logic                         out_valid_q;
	logic                         out_inside_q;
	logic                         out_edge_q;
	logic [7:0]                   out_total_q;
	logic                         out_drop_q;
	logic                         rpar_q;
	logic                         lpar_q;
	logic                         have_prev_q;

	// Vertex memory and its registered read data
	pip_pkg::coord_t              mem_x [pip_pkg::MAX_VERTICES];
	pip_pkg::coord_t              mem_y [pip_pkg::MAX_VERTICES];
	pip_pkg::coord_t              rd_x_q;
	pip_pkg::coord_t              rd_y_q;
	logic                         rd_vld_s1;

	// Translated vertex and the one before it
	pip_pkg::diff_t               dx_s2;
	pip_pkg::diff_t               dy_s2;
	logic                         vld_s2;
	pip_pkg::diff_t               px_q;
	pip_pkg::diff_t               py_q;

	logic                         accept;
	logic                         full;
	logic                         wr_en;
	logic                         rd_en;
	logic                         out_free;
	logic                         emit;
	logic                         pipe_empty;
	pip_pkg::diff_t               dx;
	pip_pkg::diff_t               dy;
	pip_pkg::edge_res_t           edge_res;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign full       = (count_q >= pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES));
	assign wr_en      = accept && (operation == pip_pkg::OP_APPEND) && !full;
	assign rd_en      = (state_q == ST_WALK);
	assign out_free   = !out_valid_q || !out_stall;
	assign emit       = (state_q == ST_EMIT) && out_free;
	assign pipe_empty = !rd_vld_s1 && !vld_s2 && !edge_res.busy && !edge_res.vld;

	// Memory: one write port for appends, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[count_q[pip_pkg::ADDR_W-1:0]] <= coord_x;
			mem_y[count_q[pip_pkg::ADDR_W-1:0]] <= coord_y;
		end
		if (rd_en) begin
			rd_x_q <= mem_x[rd_idx_q];
			rd_y_q <= mem_y[rd_idx_q];
		end
	end

	// Translate by the query point at 33 bits so nothing wraps
	assign dx = {rd_x_q[31], rd_x_q} - {qx_q[31], qx_q};
	assign dy = {rd_y_q[31], rd_y_q} - {qy_q[31], qy_q};

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			dx_s2 <= dx;
			dy_s2 <= dy;
		end
		if (vld_s2) begin
			px_q <= dx_s2;
			py_q <= dy_s2;
		end
	end

	pip_edge_eval u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.edge_vld (vld_s2 && have_prev_q),
		.xi       (dx_s2),
		.yi       (dy_s2),
		.xj       (px_q),
		.yj       (py_q),
		.res      (edge_res)
	);

	// Sequencer, store count, crossing parities and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			left_q       <= '0;
			first_q      <= 1'b0;
			qx_q         <= '0;
			qy_q         <= '0;
			res_inside_q <= 1'b0;
			res_edge_q   <= 1'b0;
			res_drop_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_inside_q <= 1'b0;
			out_edge_q   <= 1'b0;
			out_total_q  <= '0;
			out_drop_q   <= 1'b0;
			rpar_q       <= 1'b0;
			lpar_q       <= 1'b0;
			have_prev_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
			vld_s2       <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			vld_s2    <= rd_vld_s1;
			if (vld_s2) begin
				have_prev_q <= 1'b1;
			end
			if (edge_res.vld) begin
				rpar_q <= rpar_q ^ edge_res.r_hit;
				lpar_q <= lpar_q ^ edge_res.l_hit;
			end
			// load a new result, or drop the old one once it is taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_inside_q <= 1'b0;
						res_edge_q   <= 1'b0;
						res_drop_q   <= 1'b0;
						state_q      <= ST_EMIT;
						unique case (pip_pkg::op_t'(operation))
							pip_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							pip_pkg::OP_APPEND: begin
								if (full) begin
									res_drop_q <= 1'b1;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							pip_pkg::OP_TEST: begin
								qx_q        <= coord_x;
								qy_q        <= coord_y;
								rpar_q      <= 1'b0;
								lpar_q      <= 1'b0;
								have_prev_q <= 1'b0;
								if (count_q != '0) begin
									// start at the last vertex: the closing edge comes first
									rd_idx_q <= pip_pkg::ADDR_W'(count_q - 1'b1);
									left_q   <= pip_pkg::LEFT_W'(count_q) + 1'b1;
									first_q  <= 1'b1;
									state_q  <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (first_q) begin
						rd_idx_q <= '0;
						first_q  <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					left_q <= left_q - 1'b1;
					if (left_q == pip_pkg::LEFT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						// differing parities put the point on an edge
						res_edge_q   <= rpar_q ^ lpar_q;
						res_inside_q <= rpar_q | lpar_q;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_inside_q <= res_inside_q;
						out_edge_q   <= res_edge_q;
						out_total_q  <= 8'(count_q);
						out_drop_q   <= res_drop_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign inside_res   = out_inside_q;
	assign on_boundary  = out_edge_q;
	assign vertex_total = out_total_q;
	assign dropped      = out_drop_q;

endmodule

/* test/crossing_checker.sv */
// Checker that watches both channels of the polygon block and predicts its result items.
// Depends on pip_pkg; the testbench top instantiates crossing_checker beside the block.
module crossing_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic [1:0]      operation,
	input  pip_pkg::coord_t coord_x,
	input  pip_pkg::coord_t coord_y,
	input  logic            out_valid,
	input  logic            out_stall,
	input  logic            inside_res,
	input  logic            on_boundary,
	input  logic [7:0]      vertex_total,
	input  logic            dropped,
	output int              mismatch_count,
	output int              awaiting,
	output int              query_count,
	output int              inside_count,
	output int              boundary_count,
	output int              refused_count
);

	typedef struct packed {
		logic       in_poly;
		logic       on_edge;
		logic [7:0] total;
		logic       refused;
	} verdict_t;

	pip_pkg::coord_t poly_x [pip_pkg::MAX_VERTICES];
	pip_pkg::coord_t poly_y [pip_pkg::MAX_VERTICES];
	int unsigned     poly_count;
	verdict_t        pending_verdicts [$];

	// Crossing-number test of (qx, qy) against the stored polygon, closing edge included
	function automatic void classify_point(input pip_pkg::coord_t qx, input pip_pkg::coord_t qy,
			output logic in_poly, output logic on_edge);
		int unsigned right_hits, left_hits, prev;
		logic signed [69:0] xi, yi, xj, yj, num, den;
		logic up_cross, down_cross, agree;
		in_poly = 1'b0;
		on_edge = 1'b0;
		right_hits = 0;
		left_hits = 0;
		if (poly_count == 0)
			return;
		for (int unsigned k = 0; k < poly_count; k++) begin
			prev = (k == 0) ? poly_count - 1 : k - 1;
			xi = poly_x[k] - qx;
			yi = poly_y[k] - qy;
			xj = poly_x[prev] - qx;
			yj = poly_y[prev] - qy;
			up_cross = (yi > 0) != (yj > 0);
			down_cross = (yi < 0) != (yj < 0);
			if (up_cross || down_cross) begin
				// sign of the axis intersection, from numerator and denominator signs only
				num = xi * yj - xj * yi;
				den = yj - yi;
				agree = (num > 0) == (den > 0);
				if (up_cross && (num == 0 || agree))
					right_hits++;
				if (down_cross && (num == 0 || !agree))
					left_hits++;
			end
		end
		if (right_hits[0] != left_hits[0]) begin
			in_poly = 1'b1;
			on_edge = 1'b1;
		end else if (right_hits[0]) begin
			in_poly = 1'b1;
		end
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			poly_count = 0;
			pending_verdicts.delete();
			mismatch_count = 0;
			awaiting = 0;
			query_count = 0;
			inside_count = 0;
			boundary_count = 0;
			refused_count = 0;
		end else begin
			// predict on the input side first, so a same-edge result still finds its entry
			if (in_valid && !in_stall) begin
				want = '0;
				case (pip_pkg::op_t'(operation))
					pip_pkg::OP_CLEAR: begin
						poly_count = 0;
					end
					pip_pkg::OP_APPEND: begin
						if (poly_count < pip_pkg::MAX_VERTICES) begin
							poly_x[poly_count] = coord_x;
							poly_y[poly_count] = coord_y;
							poly_count++;
						end else begin
							want.refused = 1'b1;
							refused_count++;
						end
					end
					pip_pkg::OP_TEST: begin
						classify_point(coord_x, coord_y, want.in_poly, want.on_edge);
						query_count++;
						if (want.in_poly)
							inside_count++;
						if (want.on_edge)
							boundary_count++;
					end
					default: ;
				endcase
				want.total = 8'(poly_count);
				pending_verdicts = {pending_verdicts, want};
			end
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					$error("result item arrived with no prediction waiting");
					mismatch_count++;
				end else begin
					want = pending_verdicts.pop_front();
					check_field("inside_res", want.in_poly, inside_res);
					check_field("on_boundary", want.on_edge, on_boundary);
					check_field("vertex_total", want.total, vertex_total);
					check_field("dropped", want.refused, dropped);
				end
			end
			awaiting = pending_verdicts.size();
		end
	end

endmodule

/* test/testbench.sv */
// Testbench top for point_in_polygon_test: drives clear, append and query items, randomizes
// both handshakes and gives the verdict. Depends on pip_pkg and test/crossing_checker.sv.
module testbench;

	localparam int TOTAL_ITEMS = 450;
	localparam int SWAP_AT = 120;        // sender and receiver trade idle rates here
	localparam int CALM_AT = 300;        // neither side idles from here on
	localparam int SETTLE_CYCLES = 150;  // longer than a query over a full store
	localparam pip_pkg::coord_t C_MIN = pip_pkg::coord_t'(32'h8000_0000);
	localparam pip_pkg::coord_t C_MAX = pip_pkg::coord_t'(32'h7fff_ffff);

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic [1:0]      operation = 2'd0;
	pip_pkg::coord_t coord_x = '0;
	pip_pkg::coord_t coord_y = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic            inside_res;
	logic            on_boundary;
	logic [7:0]      vertex_total;
	logic            dropped;

	int mismatches, awaiting, queries, insides, boundaries, refusals;
	int idle_pct;        // chance in percent that the sender holds off one cycle
	int stall_pct;       // chance in percent that the receiver stalls a cycle
	int items_sent = 0;

	// Vertices the block should hold now; used only to aim queries at corners and edges
	pip_pkg::coord_t shape_x [$];
	pip_pkg::coord_t shape_y [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	point_in_polygon_test dut (.*);

	crossing_checker chk (
		.*,
		.mismatch_count(mismatches),
		.awaiting(awaiting),
		.query_count(queries),
		.inside_count(insides),
		.boundary_count(boundaries),
		.refused_count(refusals)
	);

	// Receiver: redraw the stall at every falling edge
	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Whole units to Q15.16
	function automatic pip_pkg::coord_t fx(input int units);
		return pip_pkg::coord_t'(units * 65536);
	endfunction

	// Grid point within +-span units, now and then with a random fraction
	function automatic pip_pkg::coord_t grid_coord(input int span);
		int u;
		u = $urandom_range(2 * span);
		if ($urandom_range(9) == 0)
			return pip_pkg::coord_t'((u - span) * 65536 + $urandom_range(65535));
		return fx(u - span);
	endfunction

	// Full-range value, biased toward the extremes and zero
	function automatic pip_pkg::coord_t wide_coord();
		case ($urandom_range(5))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			default: return pip_pkg::coord_t'($urandom);
		endcase
	endfunction

	// Send one item; call at a falling edge, returns at the falling edge after acceptance.
	// Valid is only lowered in a step that also waits, so it is never dropped and raised
	// in the same step.
	task automatic push_item(input pip_pkg::op_t op, input pip_pkg::coord_t x,
			input pip_pkg::coord_t y);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		coord_x <= x;
		coord_y <= y;
		// hold the payload until an edge sees the stall low
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
		if (op == pip_pkg::OP_CLEAR) begin
			shape_x.delete();
			shape_y.delete();
		end else if (op == pip_pkg::OP_APPEND && shape_x.size() < pip_pkg::MAX_VERTICES) begin
			shape_x = {shape_x, x};
			shape_y = {shape_y, y};
		end
	endtask

	// Query a point: grid points, stored corners, edge midpoints or anywhere at all
	task automatic probe_point();
		pip_pkg::coord_t qx, qy;
		int k, m, pick;
		pick = $urandom_range(9);
		if (shape_x.size() == 0 && pick < 8)
			pick = 0;
		if (pick < 4) begin
			// half-unit grid, so points land on axis-aligned edges often
			qx = pip_pkg::coord_t'((int'($urandom_range(28)) - 14) * 32768);
			qy = pip_pkg::coord_t'((int'($urandom_range(28)) - 14) * 32768);
		end else if (pick < 6) begin
			k = $urandom_range(shape_x.size() - 1);
			qx = shape_x[k];
			qy = shape_y[k];
		end else if (pick < 8) begin
			// edge midpoint, exact whenever both corners sit on the grid
			k = $urandom_range(shape_x.size() - 1);
			m = (k + 1) % shape_x.size();
			qx = pip_pkg::coord_t'((longint'(shape_x[k]) + longint'(shape_x[m])) >>> 1);
			qy = pip_pkg::coord_t'((longint'(shape_y[k]) + longint'(shape_y[m])) >>> 1);
		end else begin
			qx = pip_pkg::coord_t'($urandom);
			qy = pip_pkg::coord_t'($urandom);
		end
		push_item(pip_pkg::OP_TEST, qx, qy);
	endtask

	// A well-formed sequence: usually clear, then a few corners, then several queries
	task automatic run_shape(input bit wide);
		int corners;
		if ($urandom_range(9) != 0)
			push_item(pip_pkg::OP_CLEAR, pip_pkg::coord_t'($urandom),
				pip_pkg::coord_t'($urandom));
		corners = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
		repeat (corners) begin
			if (wide)
				push_item(pip_pkg::OP_APPEND, wide_coord(), wide_coord());
			else
				push_item(pip_pkg::OP_APPEND, grid_coord(6), grid_coord(6));
		end
		repeat ($urandom_range(2, 8))
			probe_point();
	endtask

	// Noise: any operation, any payload
	task automatic scramble();
		repeat ($urandom_range(3, 6))
			push_item(pip_pkg::op_t'($urandom_range(3)), pip_pkg::coord_t'($urandom),
				pip_pkg::coord_t'($urandom));
	endtask

	// Fill the store to capacity, push past it, then query the full polygon
	task automatic fill_store();
		push_item(pip_pkg::OP_CLEAR, '0, '0);
		repeat (pip_pkg::MAX_VERTICES)
			push_item(pip_pkg::OP_APPEND, grid_coord(6), grid_coord(6));
		repeat (3)
			push_item(pip_pkg::OP_APPEND, grid_coord(6), grid_coord(6));
		repeat (3)
			probe_point();
	endtask

	initial begin
		int kind;
		bit swapped;
		swapped = 1'b0;
		idle_pct = 37;
		stall_pct = 75;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty polygon, unused code, single corner
		push_item(pip_pkg::OP_TEST, '0, '0);
		push_item(pip_pkg::OP_NONE, C_MIN, C_MAX);
		push_item(pip_pkg::OP_APPEND, fx(2), fx(2));
		push_item(pip_pkg::OP_TEST, fx(2), fx(2));
		// square from (2,2) to (6,6): inside, edges, a corner, outside
		push_item(pip_pkg::OP_APPEND, fx(6), fx(2));
		push_item(pip_pkg::OP_APPEND, fx(6), fx(6));
		push_item(pip_pkg::OP_APPEND, fx(2), fx(6));
		push_item(pip_pkg::OP_TEST, fx(4), fx(4));
		push_item(pip_pkg::OP_TEST, fx(4), fx(2));
		push_item(pip_pkg::OP_TEST, fx(6), fx(6));
		push_item(pip_pkg::OP_TEST, fx(8), fx(4));
		push_item(pip_pkg::OP_TEST, fx(2), fx(4));
		push_item(pip_pkg::OP_TEST, fx(4), fx(6));
		// triangle on the coordinate extremes; its long side runs through the origin
		push_item(pip_pkg::OP_CLEAR, '0, '0);
		push_item(pip_pkg::OP_APPEND, C_MIN, C_MIN);
		push_item(pip_pkg::OP_APPEND, C_MAX, C_MIN);
		push_item(pip_pkg::OP_APPEND, C_MAX, C_MAX);
		push_item(pip_pkg::OP_TEST, C_MAX, C_MIN);
		push_item(pip_pkg::OP_TEST, '0, '0);
		push_item(pip_pkg::OP_TEST, C_MIN, C_MAX);
		push_item(pip_pkg::OP_TEST, fx(1), fx(-5));
		push_item(pip_pkg::OP_TEST, C_MAX, '0);
		push_item(pip_pkg::OP_NONE, '0, '0);
		push_item(pip_pkg::OP_CLEAR, C_MAX, C_MIN);

		// Random part in three idling phases
		while (items_sent < TOTAL_ITEMS) begin
			if (items_sent >= CALM_AT) begin
				idle_pct = 0;
				stall_pct = 0;
			end else if (items_sent >= SWAP_AT && !swapped) begin
				// drain the block completely before the roles trade
				in_valid <= 1'b0;
				do @(negedge clk); while (awaiting != 0);
				idle_pct = 75;
				stall_pct = 37;
				swapped = 1'b1;
				fill_store();
			end
			kind = $urandom_range(99);
			if (kind < 70)
				run_shape(1'b0);
			else if (kind < 88)
				run_shape(1'b1);
			else
				scramble();
		end

		// Drain, then give the block time to show any stray result item
		in_valid <= 1'b0;
		stall_pct = 0;
		do @(negedge clk); while (awaiting != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run covered %0d items: %0d point queries, %0d inside, %0d of them on an edge",
			items_sent, queries, insides, boundaries);
		$display("appends refused at capacity: %0d; mismatches: %0d", refusals, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog: its time limit is far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
